// ===== src/mdfta_pkg.sv =====
package mdfta_pkg;

   localparam int unsigned CYC_W   = 32;
   localparam int unsigned FREQ_W  = 32;
   localparam int unsigned CNT_W   = 64;
   localparam int unsigned SEL_W   = 3;
   localparam int unsigned CSR_A_W = 8;
   localparam int unsigned FREQ_REGS = 4;
   localparam logic [31:0] NS_PER_SEC = 32'd1_000_000_000;
   localparam logic [31:0] SYS_FREQ_RST = 32'd8_000_000;

   localparam logic [CSR_A_W-1:0] REG_SYS_FREQ = 8'd0;
   localparam logic [CSR_A_W-1:0] REG_DOM0     = 8'd1;
   localparam logic [CSR_A_W-1:0] REG_DOM3     = 8'd4;

   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_TAKE    = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NS_MUL,
      ST_NS_DIV,
      ST_NS_WB,
      ST_DOM_CHK,
      ST_DOM_MUL,
      ST_DOM_DIV,
      ST_DOM_WB,
      ST_TAKE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_ns;
      logic mul_dom;
      logic div_start;
      logic wb_ns;
      logic wb_dom;
      logic take;
      logic next_idx;
   } ctrl_type;

   typedef struct packed {
      logic div_done;
      logic cmd_take;
      logic dom_en;
      logic idx_end;
   } stat_type;

endpackage

// ===== src/mdfta_div.sv =====
module mdfta_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mdfta_pkg::CNT_W-1:0]     dividend,
   input  logic [mdfta_pkg::FREQ_W-1:0]    divisor,
   output logic                            done,
   output logic [mdfta_pkg::CNT_W-1:0]     quotient,
   output logic [mdfta_pkg::FREQ_W-1:0]    remainder
);

   logic [mdfta_pkg::CNT_W-1:0]  quo_ff, quo_in;
   logic [mdfta_pkg::FREQ_W-1:0] rem_ff, rem_in;
   logic [mdfta_pkg::FREQ_W-1:0] dvs_ff, dvs_in;
   logic [6:0]                   cnt_ff, cnt_in;
   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [mdfta_pkg::FREQ_W:0]   trial;
   logic [mdfta_pkg::FREQ_W:0]   diff;

   assign trial = {rem_ff, quo_ff[mdfta_pkg::CNT_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = 7'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[mdfta_pkg::FREQ_W]) begin
            rem_in = diff[mdfta_pkg::FREQ_W-1:0];
            quo_in = {quo_ff[mdfta_pkg::CNT_W-2:0], 1'b1};
         end else begin
            rem_in = trial[mdfta_pkg::FREQ_W-1:0];
            quo_in = {quo_ff[mdfta_pkg::CNT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(mdfta_pkg::CNT_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/mdfta_dp.sv =====
module mdfta_dp #(
   parameter int unsigned NUM_DOMAINS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mdfta_pkg::ctrl_type               ctrl,
   output mdfta_pkg::stat_type               stat,
   input  logic                              req_command,
   input  logic [mdfta_pkg::CYC_W-1:0]       req_cycle_count,
   input  logic [mdfta_pkg::SEL_W-1:0]       req_domain_select,
   input  logic                              csr_we,
   input  logic [mdfta_pkg::CSR_A_W-1:0]     csr_index,
   input  logic [mdfta_pkg::FREQ_W-1:0]      csr_wdata,
   output logic [mdfta_pkg::CNT_W-1:0]       rsp_total_time_ns,
   output logic [mdfta_pkg::CNT_W-1:0]       rsp_ticks_taken,
   output logic                              rsp_index_valid
);

   localparam int unsigned IW = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;
   localparam logic [mdfta_pkg::SEL_W-1:0] NDOM = mdfta_pkg::SEL_W'(NUM_DOMAINS);

   logic [mdfta_pkg::FREQ_W-1:0] sys_ff;
   logic [mdfta_pkg::FREQ_W-1:0] dfreq_ff [mdfta_pkg::FREQ_REGS];
   logic [mdfta_pkg::CNT_W-1:0]  elapsed_ff;
   logic [mdfta_pkg::FREQ_W-1:0] ns_rem_ff;
   logic [mdfta_pkg::FREQ_W-1:0] drem_ff  [NUM_DOMAINS];
   logic [mdfta_pkg::CNT_W-1:0]  dticks_ff [NUM_DOMAINS];
   logic [mdfta_pkg::CYC_W-1:0]  cyc_ff;
   logic                         cmd_ff;
   logic [mdfta_pkg::SEL_W-1:0]  idx_ff;
   logic [mdfta_pkg::CNT_W-1:0]  prod_ff;
   logic [mdfta_pkg::CNT_W-1:0]  taken_ff;
   logic                         valid_ff;

   logic [mdfta_pkg::FREQ_W-1:0] sys_eff;
   logic [mdfta_pkg::FREQ_W-1:0] cur_freq;
   logic [IW-1:0]                slot;
   logic                         idx_in_range;
   logic                         div_done;
   logic [mdfta_pkg::CNT_W-1:0]  quo;
   logic [mdfta_pkg::FREQ_W-1:0] rem;
   logic [mdfta_pkg::FREQ_W:0]   acc;
   logic                         carry;
   logic [mdfta_pkg::FREQ_W:0]   acc_adj;

   assign sys_eff      = (sys_ff == '0) ? 32'd1 : sys_ff;
   assign slot         = idx_ff[IW-1:0];
   assign idx_in_range = idx_ff < NDOM;
   assign cur_freq     = (idx_ff < 3'(mdfta_pkg::FREQ_REGS)) ? dfreq_ff[idx_ff[1:0]] : '0;

   assign acc     = {1'b0, drem_ff[slot]} + {1'b0, rem};
   assign carry   = acc >= {1'b0, sys_eff};
   assign acc_adj = carry ? (acc - {1'b0, sys_eff}) : acc;

   mdfta_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (ctrl.div_start),
      .dividend  (prod_ff),
      .divisor   (sys_eff),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sys_ff     <= mdfta_pkg::SYS_FREQ_RST;
         elapsed_ff <= '0;
         ns_rem_ff  <= '0;
         for (int i = 0; i < mdfta_pkg::FREQ_REGS; i++) begin
            dfreq_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_DOMAINS; i++) begin
            drem_ff[i]   <= '0;
            dticks_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            if (csr_index == mdfta_pkg::REG_SYS_FREQ) begin
               sys_ff <= csr_wdata;
            end else if (csr_index >= mdfta_pkg::REG_DOM0 &&
                         csr_index <= mdfta_pkg::REG_DOM3) begin
               dfreq_ff[2'(csr_index - mdfta_pkg::REG_DOM0)] <= csr_wdata;
            end
         end
         if (ctrl.wb_ns) begin
            elapsed_ff <= elapsed_ff + quo;
            ns_rem_ff  <= rem;
         end
         if (ctrl.wb_dom) begin
            drem_ff[slot]   <= acc_adj[mdfta_pkg::FREQ_W-1:0];
            dticks_ff[slot] <= dticks_ff[slot] + quo + {63'd0, carry};
         end
         if (ctrl.take && idx_in_range) begin
            dticks_ff[slot] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff   <= req_command;
         cyc_ff   <= req_cycle_count;
         idx_ff   <= (req_command == mdfta_pkg::CMD_TAKE) ? req_domain_select : '0;
         taken_ff <= '0;
         valid_ff <= 1'b0;
      end
      if (ctrl.mul_ns) begin
         prod_ff <= 64'(cyc_ff) * 64'(mdfta_pkg::NS_PER_SEC) + 64'(ns_rem_ff);
      end
      if (ctrl.mul_dom) begin
         prod_ff <= 64'(cyc_ff) * 64'(cur_freq);
      end
      if (ctrl.next_idx) begin
         idx_ff <= idx_ff + 3'd1;
      end
      if (ctrl.take && idx_in_range) begin
         taken_ff <= dticks_ff[slot];
         valid_ff <= 1'b1;
      end
   end

   assign stat.div_done = div_done;
   assign stat.cmd_take = cmd_ff;
   assign stat.dom_en   = cur_freq != '0;
   assign stat.idx_end  = !idx_in_range;

   assign rsp_total_time_ns = elapsed_ff;
   assign rsp_ticks_taken   = taken_ff;
   assign rsp_index_valid   = valid_ff;

endmodule

// ===== src/mdfta_ctrl.sv =====
module mdfta_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_strobe,
   output mdfta_pkg::ctrl_type  ctrl,
   input  mdfta_pkg::stat_type  stat
);

   mdfta_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mdfta_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         mdfta_pkg::ST_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = mdfta_pkg::ST_NS_MUL;
            end
         end
         mdfta_pkg::ST_NS_MUL: begin
            if (stat.cmd_take) begin
               state_in = mdfta_pkg::ST_TAKE;
            end else begin
               ctrl.mul_ns = 1'b1;
               state_in    = mdfta_pkg::ST_NS_DIV;
            end
         end
         mdfta_pkg::ST_NS_DIV: begin
            ctrl.div_start = 1'b1;
            state_in       = mdfta_pkg::ST_NS_WB;
         end
         mdfta_pkg::ST_NS_WB: begin
            if (stat.div_done) begin
               ctrl.wb_ns = 1'b1;
               state_in   = mdfta_pkg::ST_DOM_CHK;
            end
         end
         mdfta_pkg::ST_DOM_CHK: begin
            if (stat.idx_end) begin
               state_in = mdfta_pkg::ST_RESP;
            end else if (stat.dom_en) begin
               ctrl.mul_dom = 1'b1;
               state_in     = mdfta_pkg::ST_DOM_MUL;
            end else begin
               ctrl.next_idx = 1'b1;
            end
         end
         mdfta_pkg::ST_DOM_MUL: begin
            ctrl.div_start = 1'b1;
            state_in       = mdfta_pkg::ST_DOM_DIV;
         end
         mdfta_pkg::ST_DOM_DIV: begin
            if (stat.div_done) begin
               state_in = mdfta_pkg::ST_DOM_WB;
            end
         end
         mdfta_pkg::ST_DOM_WB: begin
            ctrl.wb_dom   = 1'b1;
            ctrl.next_idx = 1'b1;
            state_in      = mdfta_pkg::ST_DOM_CHK;
         end
         mdfta_pkg::ST_TAKE: begin
            ctrl.take = 1'b1;
            state_in  = mdfta_pkg::ST_RESP;
         end
         mdfta_pkg::ST_RESP: begin
            state_in = mdfta_pkg::ST_IDLE;
         end
         default: begin
            state_in = mdfta_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy       = state_ff != mdfta_pkg::ST_IDLE;
   assign rsp_strobe = state_ff == mdfta_pkg::ST_RESP;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("controller not idle after response");

   a_wb_after_done: assert property (@(posedge clock) disable iff (reset)
      (ctrl.wb_ns || ctrl.wb_dom) |-> !ctrl.div_start)
      else $error("write-back overlaps divider start");

endmodule

// ===== src/multi_domain_fractional_tick_accumulator_core.sv =====
// Channel   Handshake                    Payload
// req       start / busy                 req_command, req_cycle_count, req_domain_select
// rsp       rsp_strobe (one cycle)       rsp_total_time_ns, rsp_ticks_taken, rsp_index_valid
// csr       csr_valid / csr_ready        csr_index, csr_wdata
//
// Take does not use the divider. Advance runs the shared 64-step divider once
// for the time in ns and once for each enabled domain, skipping disabled ones.
// Reset is synchronous; frequencies return to their reset values and the time
// and tick counters clear. One command at a time; the receiver cannot stall a transfer.
module multi_domain_fractional_tick_accumulator_core #(
   parameter int unsigned NUM_DOMAINS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_command,
   input  logic [mdfta_pkg::CYC_W-1:0]       req_cycle_count,
   input  logic [mdfta_pkg::SEL_W-1:0]       req_domain_select,
   output logic                              rsp_strobe,
   output logic [mdfta_pkg::CNT_W-1:0]       rsp_total_time_ns,
   output logic [mdfta_pkg::CNT_W-1:0]       rsp_ticks_taken,
   output logic                              rsp_index_valid,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mdfta_pkg::CSR_A_W-1:0]     csr_index,
   input  logic [mdfta_pkg::FREQ_W-1:0]      csr_wdata
);

   mdfta_pkg::ctrl_type ctrl;
   mdfta_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   mdfta_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .ctrl       (ctrl),
      .stat       (stat)
   );

   mdfta_dp #(
      .NUM_DOMAINS (NUM_DOMAINS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .stat              (stat),
      .req_command       (req_command),
      .req_cycle_count   (req_cycle_count),
      .req_domain_select (req_domain_select),
      .csr_we            (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_total_time_ns (rsp_total_time_ns),
      .rsp_ticks_taken   (rsp_ticks_taken),
      .rsp_index_valid   (rsp_index_valid)
   );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

   localparam int unsigned NDOM = 4;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam logic [63:0] NS_SEC = 64'd1_000_000_000;

   typedef struct packed {
      logic        command;
      logic [31:0] cycles;
      logic [2:0]  sel;
      logic        has_gold;
      logic [63:0] gold_ns;
      logic [63:0] gold_ticks;
      logic        gold_valid;
   } row_type;

   typedef struct packed {
      logic [63:0] ns;
      logic [63:0] ticks;
      logic        valid;
   } tick_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_command = mdfta_pkg::CMD_ADVANCE;
   logic [mdfta_pkg::CYC_W-1:0] req_cycle_count = '0;
   logic [mdfta_pkg::SEL_W-1:0] req_domain_select = '0;
   logic rsp_strobe;
   logic [mdfta_pkg::CNT_W-1:0] rsp_total_time_ns;
   logic [mdfta_pkg::CNT_W-1:0] rsp_ticks_taken;
   logic rsp_index_valid;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [mdfta_pkg::CSR_A_W-1:0] csr_index = '0;
   logic [mdfta_pkg::FREQ_W-1:0] csr_wdata = '0;

   logic [31:0] sys_hz;
   logic [31:0] dom_hz [mdfta_pkg::FREQ_REGS];
   logic [63:0] acc_ns;
   logic [31:0] ns_rem;
   logic [31:0] dom_rem [NDOM];
   logic [63:0] dom_ticks [NDOM];

   tick_rsp_type pending_rsp [$];
   int errors = 0;
   int send_idle_pct = 24;
   longint cycle_cnt = 0;

   multi_domain_fractional_tick_accumulator_core #(.NUM_DOMAINS(NDOM)) DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("FAIL multi_domain_fractional_tick_accumulator_core");
         $finish;
      end
   end

   function automatic tick_rsp_type predict_tick(logic cmd, logic [31:0] cyc,
                                                 logic [2:0] sel);
      tick_rsp_type r;
      logic [63:0] sys;
      logic [127:0] prod;
      logic [63:0] p;
      logic [63:0] t;
      logic [63:0] a;
      r = '0;
      if (cmd == mdfta_pkg::CMD_ADVANCE) begin
         sys = (sys_hz == 0) ? 64'd1 : {32'd0, sys_hz};
         prod = {64'd0, ({32'd0, cyc} * NS_SEC + {32'd0, ns_rem})};
         acc_ns = acc_ns + prod[63:0] / sys;
         ns_rem = 32'(prod[63:0] % sys);
         for (int d = 0; d < NDOM; d++) begin
            if (d < mdfta_pkg::FREQ_REGS && dom_hz[d] != 0) begin
               p = {32'd0, cyc} * {32'd0, dom_hz[d]};
               t = p / sys;
               a = {32'd0, dom_rem[d]} + p % sys;
               if (a >= sys) begin
                  t = t + 1;
                  a = a - sys;
               end
               dom_rem[d] = a[31:0];
               dom_ticks[d] = dom_ticks[d] + t;
            end
         end
      end else if (sel < NDOM) begin
         r.ticks = dom_ticks[sel[1:0]];
         dom_ticks[sel[1:0]] = '0;
         r.valid = 1'b1;
      end
      r.ns = acc_ns;
      return r;
   endfunction

   always @(posedge clock) begin
      tick_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected transfer ns=%0d", rsp_total_time_ns);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_total_time_ns !== want.ns) begin
               $error("total_time_ns exp %0d got %0d", want.ns, rsp_total_time_ns);
               errors++;
            end
            if (rsp_ticks_taken !== want.ticks) begin
               $error("ticks_taken exp %0d got %0d", want.ticks, rsp_ticks_taken);
               errors++;
            end
            if (rsp_index_valid !== want.valid) begin
               $error("index_valid exp %0d got %0d", want.valid, rsp_index_valid);
               errors++;
            end
         end
      end
   end

   task automatic send_cmd(logic cmd, logic [31:0] cyc, logic [2:0] sel,
                           logic has_gold, tick_rsp_type gold);
      tick_rsp_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_cycle_count <= cyc;
      req_domain_select <= sel;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = predict_tick(cmd, cyc, sel);
      if (has_gold) begin
         if (r.ns !== gold.ns) begin
            $error("total_time_ns exp %0d got %0d", gold.ns, r.ns);
            errors++;
         end
         if (r.ticks !== gold.ticks) begin
            $error("ticks_taken exp %0d got %0d", gold.ticks, r.ticks);
            errors++;
         end
         if (r.valid !== gold.valid) begin
            $error("index_valid exp %0d got %0d", gold.valid, r.valid);
            errors++;
         end
      end
      pending_rsp = {pending_rsp, r};
   endtask

   task automatic drain_wait;
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_csr(logic [mdfta_pkg::CSR_A_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == mdfta_pkg::REG_SYS_FREQ) sys_hz = val;
      else if (idx inside {[mdfta_pkg::REG_DOM0 : mdfta_pkg::REG_DOM3]})
         dom_hz[2'(idx - mdfta_pkg::REG_DOM0)] = val;
      @(posedge clock);
   endtask

   task automatic random_cmd(int big);
      logic cmd;
      logic [31:0] cyc;
      cmd = ($urandom_range(99) < 65) ? mdfta_pkg::CMD_ADVANCE : mdfta_pkg::CMD_TAKE;
      case ($urandom_range(3))
         0: cyc = $urandom;
         1: cyc = $urandom_range(1000);
         2: cyc = {1'($urandom_range(1)), 31'h7fff_ffff} ^ 32'($urandom_range(1));
         default: cyc = $urandom_range(big);
      endcase
      send_cmd(cmd, cyc, 3'($urandom_range(7)), 1'b0, '0);
   endtask

   row_type rows [] = '{
      '{mdfta_pkg::CMD_TAKE, 32'd0, 3'd0, 1'b1, 64'd0, 64'd0, 1'b1},
      '{mdfta_pkg::CMD_TAKE, 32'd0, 3'd7, 1'b1, 64'd0, 64'd0, 1'b0},
      '{mdfta_pkg::CMD_TAKE, 32'd0, 3'd4, 1'b1, 64'd0, 64'd0, 1'b0},
      '{mdfta_pkg::CMD_ADVANCE, 32'd8, 3'd0, 1'b1, 64'd1000, 64'd0, 1'b0},
      '{mdfta_pkg::CMD_ADVANCE, 32'd0, 3'd7, 1'b1, 64'd1000, 64'd0, 1'b0},
      '{mdfta_pkg::CMD_ADVANCE, 32'd3, 3'd0, 1'b0, 64'd0, 64'd0, 1'b0},
      '{mdfta_pkg::CMD_ADVANCE, 32'd5, 3'd0, 1'b0, 64'd0, 64'd0, 1'b0},
      '{mdfta_pkg::CMD_ADVANCE, 32'hffff_ffff, 3'd0, 1'b0, 64'd0, 64'd0, 1'b0},
      '{mdfta_pkg::CMD_TAKE, 32'hffff_ffff, 3'd3, 1'b0, 64'd0, 64'd0, 1'b0}
   };

   row_type dom_rows [] = '{
      '{mdfta_pkg::CMD_ADVANCE, 32'd7, 3'd0, 1'b0, 64'd0, 64'd0, 1'b0},
      '{mdfta_pkg::CMD_ADVANCE, 32'hffff_ffff, 3'd5, 1'b0, 64'd0, 64'd0, 1'b0},
      '{mdfta_pkg::CMD_TAKE, 32'd0, 3'd0, 1'b0, 64'd0, 64'd0, 1'b0},
      '{mdfta_pkg::CMD_TAKE, 32'd0, 3'd1, 1'b0, 64'd0, 64'd0, 1'b0},
      '{mdfta_pkg::CMD_TAKE, 32'd0, 3'd2, 1'b0, 64'd0, 64'd0, 1'b0},
      '{mdfta_pkg::CMD_TAKE, 32'd0, 3'd3, 1'b0, 64'd0, 64'd0, 1'b0},
      '{mdfta_pkg::CMD_TAKE, 32'd0, 3'd3, 1'b0, 64'd0, 64'd0, 1'b0},
      '{mdfta_pkg::CMD_TAKE, 32'd0, 3'd6, 1'b0, 64'd0, 64'd0, 1'b0}
   };

   initial begin
      sys_hz = mdfta_pkg::SYS_FREQ_RST;
      acc_ns = '0;
      ns_rem = '0;
      for (int d = 0; d < mdfta_pkg::FREQ_REGS; d++) dom_hz[d] = '0;
      for (int d = 0; d < NDOM; d++) begin
         dom_rem[d] = '0;
         dom_ticks[d] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send_cmd(rows[i].command, rows[i].cycles, rows[i].sel, rows[i].has_gold,
                  '{rows[i].gold_ns, rows[i].gold_ticks, rows[i].gold_valid});
      end
      drain_wait();

      write_csr(mdfta_pkg::REG_SYS_FREQ, 32'd3);
      write_csr(mdfta_pkg::REG_DOM0, 32'hffff_ffff);
      write_csr(8'(mdfta_pkg::REG_DOM0 + 1), 32'd1);
      write_csr(8'(mdfta_pkg::REG_DOM0 + 2), 32'd0);
      write_csr(mdfta_pkg::REG_DOM3, 32'd2);
      write_csr(8'd200, 32'd5);
      foreach (dom_rows[i]) begin
         send_cmd(dom_rows[i].command, dom_rows[i].cycles, dom_rows[i].sel, 1'b0, '0);
      end
      drain_wait();
      // lower system frequency below stored remainders
      write_csr(mdfta_pkg::REG_SYS_FREQ, 32'd1);
      send_cmd(mdfta_pkg::CMD_ADVANCE, 32'd1, 3'd0, 1'b0, '0);
      drain_wait();

      for (int ph = 0; ph < 7; ph++) begin
         if (ph == 2) send_idle_pct = 63;
         if (ph == 4) send_idle_pct = 0;
         case (ph)
            0: write_csr(mdfta_pkg::REG_SYS_FREQ, 32'hffff_ffff);
            1: write_csr(mdfta_pkg::REG_SYS_FREQ, 32'd0);
            2: write_csr(mdfta_pkg::REG_SYS_FREQ, 32'd8_000_000);
            default: write_csr(mdfta_pkg::REG_SYS_FREQ, $urandom);
         endcase
         for (int r = 0; r < mdfta_pkg::FREQ_REGS; r++) begin
            case ($urandom_range(3))
               0: write_csr(8'(mdfta_pkg::REG_DOM0 + r), 32'd0);
               1: write_csr(8'(mdfta_pkg::REG_DOM0 + r), 32'hffff_ffff);
               default: write_csr(8'(mdfta_pkg::REG_DOM0 + r), $urandom);
            endcase
         end
         for (int k = 0; k < 150; k++) random_cmd(ph == 1 ? 50 : 100_000);
         drain_wait();
      end

      if (errors == 0) begin
         $display("PASS multi_domain_fractional_tick_accumulator_core");
      end else begin
         $display("FAIL multi_domain_fractional_tick_accumulator_core");
      end
      $finish;
   end
endmodule
